FILE: src/packet_deframer_checksum_check_assert.svh
// assertion macros shared by the deframer rtl
// no dependencies; modules take this file in by include
`ifndef PACKET_DEFRAMER_CHECKSUM_CHECK_ASSERT_SVH
`define PACKET_DEFRAMER_CHECKSUM_CHECK_ASSERT_SVH

// same-cycle implication, held off during reset
`define PDCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define PDCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pdcc_pkg.sv
// shared types, marker codes and hex decode for the packet deframer
// no dependencies
package pdcc_pkg;

    typedef logic [7:0] t_byte;

    // frame markers
    localparam t_byte START_MARK = 8'h24;
    localparam t_byte END_MARK   = 8'h23;

    // one result transaction
    typedef struct packed {
        t_byte data_byte;
        logic  frame_end;
        logic  frame_good;
    } t_result;

    // decoded checksum digit
    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } t_hex;

    // hex digit in either case, flagged bad otherwise
    function automatic t_hex hex_digit(input t_byte b);
        t_hex h;
        h.bad   = 1'b0;
        h.value = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

FILE: src/pdcc_in_if.sv
// input channel: one received byte per transaction
// depends on pdcc_pkg
interface pdcc_in_if;
    logic           valid;
    logic           ready;
    pdcc_pkg::t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: src/pdcc_out_if.sv
// output channel: payload byte or frame-end result per transaction
// depends on pdcc_pkg
interface pdcc_out_if;
    logic            valid;
    logic            ready;
    pdcc_pkg::t_byte data_byte;
    logic            frame_end;
    logic            frame_good;

    modport source (output valid, output data_byte, output frame_end, output frame_good,
                    input ready);
    modport sink   (input valid, input data_byte, input frame_end, input frame_good,
                    output ready);
endinterface

FILE: src/packet_deframer_checksum_check.sv
// a payload byte or frame-end result is registered before it is offered on the output
// throughput: one received byte per cycle; input stalls only when the output holds
// two results unaccepted (output register plus skid entry)
// reset (synchronous, active low) returns to hunting for the start marker with all
// result slots empty
// depends on pdcc_pkg, pdcc_in_if, pdcc_out_if, pdcc_core and pdcc_skid
module packet_deframer_checksum_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdcc_in_if.sink     i_rx,
    pdcc_out_if.source  o_res
);

    logic              w_ready;
    logic              w_accept;
    logic              w_res_valid;
    pdcc_pkg::t_result w_res;
    pdcc_pkg::t_result w_out;

    // input transaction
    assign i_rx.ready = w_ready;
    assign w_accept   = i_rx.valid && w_ready;

    pdcc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_rx.rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    pdcc_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_data      (w_res),
        .o_in_ready  (w_ready),
        .o_valid     (o_res.valid),
        .o_data      (w_out),
        .i_out_ready (o_res.ready)
    );

    // result fields
    assign o_res.data_byte  = w_out.data_byte;
    assign o_res.frame_end  = w_out.frame_end;
    assign o_res.frame_good = w_out.frame_good;

endmodule

FILE: src/pdcc_core.sv
// frame state machine: marker hunt, payload sum and checksum compare
// depends on pdcc_pkg and packet_deframer_checksum_check_assert.svh
`include "packet_deframer_checksum_check_assert.svh"

module pdcc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  pdcc_pkg::t_byte   i_byte,
    output logic              o_res_valid,
    output pdcc_pkg::t_result o_res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_PAYLOAD,
        PH_DIGIT_HI,
        PH_DIGIT_LO
    } t_phase;

    t_phase          r_phase, n_phase;
    pdcc_pkg::t_byte r_sum, n_sum;
    logic [3:0]      r_high, n_high;
    logic            r_high_bad, n_high_bad;
    pdcc_pkg::t_hex  w_hex;

    assign w_hex = pdcc_pkg::hex_digit(i_byte);

    // next state and result for the byte in this transaction
    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_high      = r_high;
        n_high_bad  = r_high_bad;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_byte == pdcc_pkg::START_MARK) begin
                        n_sum   = '0;
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (i_byte == pdcc_pkg::END_MARK) begin
                        n_phase = PH_DIGIT_HI;
                    end else begin
                        n_sum           = r_sum + i_byte;
                        o_res_valid     = 1'b1;
                        o_res.data_byte = i_byte;
                    end
                end
                PH_DIGIT_HI: begin
                    n_high     = w_hex.value;
                    n_high_bad = w_hex.bad;
                    n_phase    = PH_DIGIT_LO;
                end
                PH_DIGIT_LO: begin
                    o_res_valid      = 1'b1;
                    o_res.frame_end  = 1'b1;
                    o_res.frame_good = !r_high_bad && !w_hex.bad &&
                                       ({r_high, w_hex.value} == r_sum);
                    n_phase          = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_sum      <= '0;
            r_high     <= '0;
            r_high_bad <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_sum      <= n_sum;
            r_high     <= n_high;
            r_high_bad <= n_high_bad;
        end
    end

    // a start marker opens a frame with a cleared sum
    `PDCC_ASSERT_NXT(a_start_clears, i_clk, i_rst_n,
        i_accept && r_phase == PH_HUNT && i_byte == pdcc_pkg::START_MARK,
        r_phase == PH_PAYLOAD && r_sum == '0, "start marker did not open a frame")
    // results come only from payload bytes or the second digit
    `PDCC_ASSERT_IMP(a_res_phase, i_clk, i_rst_n, o_res_valid,
        i_accept && (r_phase == PH_PAYLOAD || r_phase == PH_DIGIT_LO),
        "result outside payload or second digit")
    // the second digit always returns to hunting
    `PDCC_ASSERT_NXT(a_end_hunts, i_clk, i_rst_n, o_res_valid && o_res.frame_end,
        r_phase == PH_HUNT && $past(r_phase) == PH_DIGIT_LO, "frame end did not rearm hunt")

endmodule

FILE: src/pdcc_skid.sv
// output register with one skid entry; input waits on output ready only while the skid entry is full
// depends on pdcc_pkg and packet_deframer_checksum_check_assert.svh
`include "packet_deframer_checksum_check_assert.svh"

module pdcc_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pdcc_pkg::t_result i_data,
    output logic              o_in_ready,
    output logic              o_valid,
    output pdcc_pkg::t_result o_data,
    input  logic              i_out_ready
);

    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    pdcc_pkg::t_result r_out, n_out;
    pdcc_pkg::t_result r_skid, n_skid;
    logic              w_take;

    assign w_take     = r_out_valid && i_out_ready;
    assign o_in_ready = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    // refill the output register from the skid entry first, then from input
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || w_take) begin
                n_out       = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // the skid entry is only used behind a full output register
    `PDCC_ASSERT_IMP(a_skid_behind, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid entry held with empty output register")
    // a stalled result with a new push lands in the skid entry
    `PDCC_ASSERT_NXT(a_skid_fill, i_clk, i_rst_n,
        i_push && o_in_ready && r_out_valid && !i_out_ready,
        r_skid_valid && r_skid == $past(i_data), "stalled push not captured in skid")

endmodule
